// ===== rtl/core/fcbg_pkg.sv =====
// ----------------------------------------------------------------------------
// fcbg_pkg - shared definitions for the four-corner bilinear gradient
// Widths, register indexes and the structs passed between the blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package fcbg_pkg;

    // largest supported width or height; larger settings clamp to this
    localparam int MAX_DIM  = 4096;

    localparam int COORD_W  = 12;                      // pixel_x / pixel_y
    localparam int CFG_DIM_W = 13;                     // width / height registers
    localparam int COLOR_W  = 24;                      // packed RGB register
    localparam int CHAN_W   = 8;                       // one color channel
    localparam int NUM_CHAN = 3;
    localparam int NUM_CORNERS = 4;

    localparam int DIM_W    = $clog2(MAX_DIM + 1);     // clamped dimension
    localparam int CALC_W   = (DIM_W > COORD_W) ? DIM_W : COORD_W + 1;
    localparam int AREA_W   = 2 * DIM_W;               // weights and w*h
    localparam int SUM_W    = AREA_W + CHAN_W;         // weighted channel sum

    // one division cell per quotient bit
    localparam int NUM_CELLS = CHAN_W;
    localparam int BIT_IDX_W = $clog2(NUM_CELLS);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COLOR_W;

    localparam logic [CFG_IDX_W-1:0] REG_TOP_LEFT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_RIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_LEFT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_RIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT       = 3'd5;

    localparam logic [CFG_DIM_W-1:0] DIM_RESET = 13'd256;

    // corner order inside the color array
    localparam int CORNER_TL = 0;
    localparam int CORNER_TR = 1;
    localparam int CORNER_BL = 2;
    localparam int CORNER_BR = 3;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [NUM_CORNERS-1:0][COLOR_W-1:0] color;
        logic [CFG_DIM_W-1:0]                width;
        logic [CFG_DIM_W-1:0]                height;
    } cfg_t;

    // payload moving through the divider chain
    typedef struct packed {
        logic                               oor;
        logic [AREA_W-1:0]                  area;
        logic [NUM_CHAN-1:0][SUM_W-1:0]     rem;
        logic [NUM_CHAN-1:0][CHAN_W-1:0]    quo;
    } cell_data_t;

    // finished pixel
    typedef struct packed {
        logic              oor;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pix_t;

endpackage

`default_nettype wire

// ===== rtl/core/four_corner_bilinear_gradient_top.sv =====
// ----------------------------------------------------------------------------
// four_corner_bilinear_gradient_top - four-corner bilinear color gradient
// Blends four corner colors at a pixel coordinate, one pixel per clock unless held.
// ----------------------------------------------------------------------------
// Takes one coordinate beat per clock unless held and returns one color beat
// per coordinate, in order. Each channel is the bilinear blend of the four
// corner colors divided by width*height and rounded down; width and height
// clamp to MAX_DIM, and a coordinate outside them returns zeros with the
// out-of-range flag set. The pipe: four front-end stages (range check, corner
// weights, channel products, sums), a chain of eight division cells that each
// resolve one quotient bit, and the output register. Throughput is one pixel
// every cycle while the skid stage is empty; the pipe holds while it is full,
// and the input reopens in the cycle after the sink takes a beat. The user
// writes configuration while no pixel is in flight; nothing enforces this.
// ----------------------------------------------------------------------------
`default_nettype none

module four_corner_bilinear_gradient_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [fcbg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fcbg_pkg::CFG_DATA_W-1:0] cfg_data,
    // coordinate stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [23:0]                     s_tdata,   // pixel_x[11:0], pixel_y[23:12]
    // color stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [23:0]                          m_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic [0:0]                           m_tuser    // out_of_range[0]
);

    localparam int NUM_CELLS = fcbg_pkg::NUM_CELLS;

    // ---- configuration registers ----
    fcbg_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color  <= '0;
            cfg_reg.width  <= fcbg_pkg::DIM_RESET;
            cfg_reg.height <= fcbg_pkg::DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fcbg_pkg::REG_TOP_LEFT:
                    cfg_reg.color[fcbg_pkg::CORNER_TL] <= cfg_data;
                fcbg_pkg::REG_TOP_RIGHT:
                    cfg_reg.color[fcbg_pkg::CORNER_TR] <= cfg_data;
                fcbg_pkg::REG_BOTTOM_LEFT:
                    cfg_reg.color[fcbg_pkg::CORNER_BL] <= cfg_data;
                fcbg_pkg::REG_BOTTOM_RIGHT:
                    cfg_reg.color[fcbg_pkg::CORNER_BR] <= cfg_data;
                fcbg_pkg::REG_WIDTH:
                    cfg_reg.width  <= cfg_data[fcbg_pkg::CFG_DIM_W-1:0];
                fcbg_pkg::REG_HEIGHT:
                    cfg_reg.height <= cfg_data[fcbg_pkg::CFG_DIM_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // ---- pipe advance: held while the skid stage is occupied ----
    logic en;
    logic skid_ready;
    assign en       = skid_ready;
    assign s_tready = en;

    // ---- front end ----
    logic                 fe_valid;
    fcbg_pkg::cell_data_t fe_data;

    fcbg_weight u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .pixel_x   (s_tdata[11:0]),
        .pixel_y   (s_tdata[23:12]),
        .cfg       (cfg_reg),
        .out_valid (fe_valid),
        .out_data  (fe_data)
    );

    // ---- divider chain, most significant quotient bit first ----
    logic                 chain_valid [NUM_CELLS+1];
    fcbg_pkg::cell_data_t chain_data  [NUM_CELLS+1];

    assign chain_valid[0] = fe_valid;
    assign chain_data[0]  = fe_data;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        fcbg_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .bit_idx   (fcbg_pkg::BIT_IDX_W'(NUM_CELLS - 1 - i)),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // ---- result: zero colors when out of range ----
    fcbg_pkg::pix_t pix_c;
    fcbg_pkg::pix_t pix_out;

    always_comb
    begin
        pix_c.oor = chain_data[NUM_CELLS].oor;
        if (chain_data[NUM_CELLS].oor)
        begin
            pix_c.red   = '0;
            pix_c.green = '0;
            pix_c.blue  = '0;
        end
        else
        begin
            pix_c.red   = chain_data[NUM_CELLS].quo[0];
            pix_c.green = chain_data[NUM_CELLS].quo[1];
            pix_c.blue  = chain_data[NUM_CELLS].quo[2];
        end
    end

    fcbg_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[NUM_CELLS] && en),
        .in_data   (pix_c),
        .in_ready  (skid_ready),
        .out_valid (m_tvalid),
        .out_data  (pix_out),
        .out_ready (m_tready)
    );

    assign m_tdata = {pix_out.blue, pix_out.green, pix_out.red};
    assign m_tuser = pix_out.oor;

endmodule

`default_nettype wire

// ===== rtl/core/fcbg_weight.sv =====
// ----------------------------------------------------------------------------
// fcbg_weight - corner weights and weighted channel sums
// Four-stage front end: range check, corner weights, channel products, sums.
// ----------------------------------------------------------------------------
`default_nettype none

module fcbg_weight (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire logic [fcbg_pkg::COORD_W-1:0] pixel_x,
    input  wire logic [fcbg_pkg::COORD_W-1:0] pixel_y,
    input  wire fcbg_pkg::cfg_t               cfg,
    output logic                              out_valid,
    output fcbg_pkg::cell_data_t              out_data
);

    localparam int DIM_W  = fcbg_pkg::DIM_W;
    localparam int CALC_W = fcbg_pkg::CALC_W;
    localparam int AREA_W = fcbg_pkg::AREA_W;
    localparam int SUM_W  = fcbg_pkg::SUM_W;
    localparam int CHAN_W = fcbg_pkg::CHAN_W;
    localparam int NCH    = fcbg_pkg::NUM_CHAN;
    localparam int NCR    = fcbg_pkg::NUM_CORNERS;

    // ---- stage 1: clamp dimensions, range check, edge distances ----
    logic [CALC_W-1:0] w_c, h_c, x_e, y_e;
    logic              oor_c;

    always_comb
    begin
        if (cfg.width > fcbg_pkg::MAX_DIM)
            w_c = CALC_W'(fcbg_pkg::MAX_DIM);
        else
            w_c = CALC_W'(cfg.width);
        if (cfg.height > fcbg_pkg::MAX_DIM)
            h_c = CALC_W'(fcbg_pkg::MAX_DIM);
        else
            h_c = CALC_W'(cfg.height);
        x_e   = CALC_W'(pixel_x);
        y_e   = CALC_W'(pixel_y);
        oor_c = (x_e >= w_c) || (y_e >= h_c);
    end

    logic              s1_valid_reg;
    logic              s1_oor_reg;
    logic [DIM_W-1:0]  s1_x_reg, s1_y_reg, s1_dx_reg, s1_dy_reg, s1_w_reg, s1_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_oor_reg <= oor_c;
            s1_x_reg   <= DIM_W'(x_e);
            s1_y_reg   <= DIM_W'(y_e);
            s1_dx_reg  <= DIM_W'(w_c - x_e);
            s1_dy_reg  <= DIM_W'(h_c - y_e);
            s1_w_reg   <= DIM_W'(w_c);
            s1_h_reg   <= DIM_W'(h_c);
        end
    end

    // ---- stage 2: corner weights and area ----
    logic                         s2_valid_reg;
    logic                         s2_oor_reg;
    logic [NCR-1:0][AREA_W-1:0]   s2_wt_reg;
    logic [AREA_W-1:0]            s2_area_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_oor_reg <= s1_oor_reg;
            s2_wt_reg[fcbg_pkg::CORNER_TL] <= AREA_W'(s1_dy_reg) * AREA_W'(s1_dx_reg);
            s2_wt_reg[fcbg_pkg::CORNER_TR] <= AREA_W'(s1_dy_reg) * AREA_W'(s1_x_reg);
            s2_wt_reg[fcbg_pkg::CORNER_BL] <= AREA_W'(s1_y_reg)  * AREA_W'(s1_dx_reg);
            s2_wt_reg[fcbg_pkg::CORNER_BR] <= AREA_W'(s1_y_reg)  * AREA_W'(s1_x_reg);
            s2_area_reg <= AREA_W'(s1_w_reg) * AREA_W'(s1_h_reg);
        end
    end

    // ---- stage 3: channel times weight for every corner ----
    logic                                 s3_valid_reg;
    logic                                 s3_oor_reg;
    logic [AREA_W-1:0]                    s3_area_reg;
    logic [NCH-1:0][NCR-1:0][SUM_W-1:0]   s3_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= s2_valid_reg;
    end

    // channel 0 is red in the top byte of the packed color
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_oor_reg  <= s2_oor_reg;
            s3_area_reg <= s2_area_reg;
            for (int ch = 0; ch < NCH; ch++)
            begin
                for (int k = 0; k < NCR; k++)
                begin
                    s3_prod_reg[ch][k] <=
                        SUM_W'(cfg.color[k][(NCH-1-ch)*CHAN_W +: CHAN_W]) *
                        SUM_W'(s2_wt_reg[k]);
                end
            end
        end
    end

    // ---- stage 4: sums, seeding the divider chain ----
    logic                        s4_valid_reg;
    fcbg_pkg::cell_data_t        s4_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (en)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_data_reg.oor  <= s3_oor_reg;
            s4_data_reg.area <= s3_area_reg;
            s4_data_reg.quo  <= '0;
            for (int ch = 0; ch < NCH; ch++)
            begin
                s4_data_reg.rem[ch] <= s3_prod_reg[ch][0] + s3_prod_reg[ch][1]
                                     + s3_prod_reg[ch][2] + s3_prod_reg[ch][3];
            end
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_data  = s4_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/fcbg_div_cell.sv =====
// ----------------------------------------------------------------------------
// fcbg_div_cell - one restoring-division cell
// Resolves one quotient bit for all three channels and passes on the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module fcbg_div_cell (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire logic [fcbg_pkg::BIT_IDX_W-1:0] bit_idx,
    input  wire logic                           in_valid,
    input  wire fcbg_pkg::cell_data_t           in_data,
    output logic                                out_valid,
    output fcbg_pkg::cell_data_t                out_data
);

    localparam int SUM_W = fcbg_pkg::SUM_W;

    logic [SUM_W-1:0]      divisor;
    fcbg_pkg::cell_data_t  data_next;
    fcbg_pkg::cell_data_t  data_reg;
    logic                  valid_reg;

    // trial subtract of area shifted to this cell's bit weight
    always_comb
    begin
        divisor   = SUM_W'(in_data.area) << bit_idx;
        data_next = in_data;
        for (int ch = 0; ch < fcbg_pkg::NUM_CHAN; ch++)
        begin
            if (in_data.rem[ch] >= divisor)
            begin
                data_next.rem[ch]          = in_data.rem[ch] - divisor;
                data_next.quo[ch][bit_idx] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/fcbg_skid.sv =====
// ----------------------------------------------------------------------------
// fcbg_skid - output register with skid stage
// Holds one beat in flight while the sink stalls; ready is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fcbg_skid (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire fcbg_pkg::pix_t in_data,
    output logic                in_ready,
    output logic                out_valid,
    output fcbg_pkg::pix_t      out_data,
    input  wire logic           out_ready
);

    logic           out_valid_reg;
    logic           skid_valid_reg;
    fcbg_pkg::pix_t out_data_reg;
    fcbg_pkg::pix_t skid_data_reg;

    logic out_free;
    assign out_free = !out_valid_reg || out_ready;

    // control: output slot and skid slot occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_ready)
                    skid_valid_reg <= 1'b0;
            end
            else if (in_valid)
            begin
                out_valid_reg <= 1'b1;
                if (!out_free)
                    skid_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
                out_data_reg <= skid_data_reg;
        end
        else if (in_valid)
        begin
            if (out_free)
                out_data_reg <= in_data;
            else
                skid_data_reg <= in_data;
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
